>>> src/c6502eu_pkg.sv
// Package for the 6502 execute unit: opcode codes, field codes and flag positions.
package c6502eu_pkg;

  // Opcode groups (bits 7:5) for the ALU column
  localparam logic [2:0] GRP_ORA = 3'd0;
  localparam logic [2:0] GRP_AND = 3'd1;
  localparam logic [2:0] GRP_EOR = 3'd2;
  localparam logic [2:0] GRP_ADC = 3'd3;
  localparam logic [2:0] GRP_STA = 3'd4;
  localparam logic [2:0] GRP_LDA = 3'd5;
  localparam logic [2:0] GRP_CMP = 3'd6;
  localparam logic [2:0] GRP_SBC = 3'd7;

  // Shift groups share the same field
  localparam logic [2:0] GRP_ASL = 3'd0;
  localparam logic [2:0] GRP_LSR = 3'd2;

  // Addressing forms (bits 4:2)
  localparam logic [2:0] MODE_IMM  = 3'd2;
  localparam logic [2:0] MODE_ZP   = 3'd1;
  localparam logic [2:0] MODE_ABS  = 3'd3;
  localparam logic [2:0] MODE_ZPX  = 3'd5;
  localparam logic [2:0] MODE_ABSX = 3'd7;

  // Column codes (bits 1:0)
  localparam logic [1:0] COL_ALU   = 2'b01;
  localparam logic [1:0] COL_SHIFT = 2'b10;

  // Branch pattern in bits 4:0
  localparam logic [4:0] BRANCH_LOW = 5'b10000;

  // Branch flag select (bits 7:6)
  localparam logic [1:0] BSEL_N = 2'd0;
  localparam logic [1:0] BSEL_V = 2'd1;
  localparam logic [1:0] BSEL_C = 2'd2;
  localparam logic [1:0] BSEL_Z = 2'd3;

  // Single opcodes
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_BIT_ABS = 8'h2C;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_NOP     = 8'hEA;
  localparam logic [7:0] OP_BRK     = 8'h00;

  // Status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

endpackage

>>> src/c6502eu_if.sv
// Request and result channel interfaces of the 6502 execute unit.
interface c6502eu_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [7:0]  operand;
  logic [15:0] pc_after;

  modport source (output valid, output opcode, output operand, output pc_after, input ready);
  modport sink   (input valid, input opcode, input operand, input pc_after, output ready);
endinterface

interface c6502eu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  a_out;
  logic [7:0]  x_out;
  logic [7:0]  y_out;
  logic [7:0]  p_out;
  logic        write_enable;
  logic [7:0]  write_data;
  logic [15:0] next_pc;
  logic        halted;
  logic        illegal;

  modport source (output valid, output a_out, output x_out, output y_out, output p_out,
                  output write_enable, output write_data, output next_pc,
                  output halted, output illegal, input ready);
  modport sink   (input valid, input a_out, input x_out, input y_out, input p_out,
                  input write_enable, input write_data, input next_pc,
                  input halted, input illegal, output ready);
endinterface

>>> src/cpu_6502_execute_unit.sv
// 6502 execute unit: input register, single-pass execute logic, result register.
// A request waits in the input register until the result register is free or being
// drained. It takes one request per cycle while the receiver takes results; the execute
// logic between the two registers updates A, X, Y and P as the request moves on.
// Reset clears A, X, Y, P and both valid bits; payload registers are not reset.
module cpu_6502_execute_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  c6502eu_in_if.sink       req_i,
  c6502eu_out_if.source    rsp_o
);

  // Input stage
  logic        in_vld_q;
  logic [7:0]  op_q;
  logic [7:0]  opd_q;
  logic [15:0] pc_q;

  // Architectural state
  logic [7:0] a_q, a_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] p_q, p_d;

  // Result register
  logic        out_vld_q;
  logic        we_q, we_d;
  logic [7:0]  wd_q, wd_d;
  logic [15:0] npc_q, npc_d;
  logic        halt_q, halt_d;
  logic        bad_q, bad_d;

  logic advance;

  // Input stage moves on when the result register is free or being drained
  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      op_q  <= req_i.opcode;
      opd_q <= req_i.operand;
      pc_q  <= req_i.pc_after;
    end
  end

  // Execute logic
  always_comb begin
    logic [2:0] grp;
    logic [2:0] mode;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] src;
    logic [7:0] shres;
    logic [7:0] res;
    logic       flag;
    logic       taken;
    grp    = op_q[7:5];
    mode   = op_q[4:2];
    addend = (grp == c6502eu_pkg::GRP_SBC) ? ~opd_q : opd_q;
    sum    = {1'b0, a_q} + {1'b0, addend} + {8'd0, p_q[c6502eu_pkg::FLAG_C]};
    src    = (mode == c6502eu_pkg::MODE_IMM) ? a_q : opd_q;
    shres  = (grp == c6502eu_pkg::GRP_ASL) ? {src[6:0], 1'b0} : {1'b0, src[7:1]};
    res    = 8'd0;
    flag   = 1'b0;
    taken  = 1'b0;

    a_d    = a_q;
    x_d    = x_q;
    y_d    = y_q;
    p_d    = p_q;
    we_d   = 1'b0;
    wd_d   = 8'd0;
    npc_d  = pc_q;
    halt_d = 1'b0;
    bad_d  = 1'b0;

    if (op_q[1:0] == c6502eu_pkg::COL_ALU
        && !(grp == c6502eu_pkg::GRP_STA && mode == c6502eu_pkg::MODE_IMM)
        && grp != c6502eu_pkg::GRP_CMP) begin
      // ALU column
      case (grp)
        c6502eu_pkg::GRP_ORA: res = a_q | opd_q;
        c6502eu_pkg::GRP_AND: res = a_q & opd_q;
        c6502eu_pkg::GRP_EOR: res = a_q ^ opd_q;
        c6502eu_pkg::GRP_LDA: res = opd_q;
        c6502eu_pkg::GRP_STA: res = a_q;
        default: begin
          // ADC and SBC
          res = sum[7:0];
          p_d[c6502eu_pkg::FLAG_C] = sum[8];
          p_d[c6502eu_pkg::FLAG_V] = ~(a_q[7] ^ addend[7]) & (a_q[7] ^ sum[7]);
        end
      endcase
      if (grp == c6502eu_pkg::GRP_STA) begin
        we_d = 1'b1;
        wd_d = a_q;
      end else begin
        a_d = res;
        p_d[c6502eu_pkg::FLAG_Z] = (res == 8'd0);
        p_d[c6502eu_pkg::FLAG_N] = res[7];
      end
    end else if (op_q[1:0] == c6502eu_pkg::COL_SHIFT
                 && (grp == c6502eu_pkg::GRP_ASL || grp == c6502eu_pkg::GRP_LSR)
                 && (mode == c6502eu_pkg::MODE_ZP || mode == c6502eu_pkg::MODE_IMM
                     || mode == c6502eu_pkg::MODE_ABS || mode == c6502eu_pkg::MODE_ZPX
                     || mode == c6502eu_pkg::MODE_ABSX)) begin
      // ASL / LSR, accumulator form uses the immediate slot
      p_d[c6502eu_pkg::FLAG_C] = (grp == c6502eu_pkg::GRP_ASL) ? src[7] : src[0];
      p_d[c6502eu_pkg::FLAG_Z] = (shres == 8'd0);
      p_d[c6502eu_pkg::FLAG_N] = shres[7];
      if (mode == c6502eu_pkg::MODE_IMM) begin
        a_d = shres;
      end else begin
        we_d = 1'b1;
        wd_d = shres;
      end
    end else if (op_q[4:0] == c6502eu_pkg::BRANCH_LOW) begin
      // Conditional branches
      case (op_q[7:6])
        c6502eu_pkg::BSEL_N: flag = p_q[c6502eu_pkg::FLAG_N];
        c6502eu_pkg::BSEL_V: flag = p_q[c6502eu_pkg::FLAG_V];
        c6502eu_pkg::BSEL_C: flag = p_q[c6502eu_pkg::FLAG_C];
        default:             flag = p_q[c6502eu_pkg::FLAG_Z];
      endcase
      taken = op_q[5] ? flag : !flag;
      if (taken) begin
        npc_d = pc_q + {{8{opd_q[7]}}, opd_q};
      end
    end else if (op_q == c6502eu_pkg::OP_BIT_ZP || op_q == c6502eu_pkg::OP_BIT_ABS) begin
      p_d[c6502eu_pkg::FLAG_Z] = ((a_q & opd_q) == 8'd0);
      p_d[c6502eu_pkg::FLAG_N] = opd_q[7];
      p_d[c6502eu_pkg::FLAG_V] = opd_q[6];
    end else if (op_q == c6502eu_pkg::OP_TAX) begin
      x_d = a_q;
      p_d[c6502eu_pkg::FLAG_Z] = (a_q == 8'd0);
      p_d[c6502eu_pkg::FLAG_N] = a_q[7];
    end else if (op_q == c6502eu_pkg::OP_INX) begin
      x_d = x_q + 8'd1;
      p_d[c6502eu_pkg::FLAG_Z] = (x_d == 8'd0);
      p_d[c6502eu_pkg::FLAG_N] = x_d[7];
    end else if (op_q == c6502eu_pkg::OP_INY) begin
      y_d = y_q + 8'd1;
      p_d[c6502eu_pkg::FLAG_Z] = (y_d == 8'd0);
      p_d[c6502eu_pkg::FLAG_N] = y_d[7];
    end else if (op_q == c6502eu_pkg::OP_NOP) begin
      // nothing changes
    end else if (op_q == c6502eu_pkg::OP_BRK) begin
      halt_d = 1'b1;
    end else begin
      bad_d = 1'b1;
    end
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q       <= 8'd0;
      x_q       <= 8'd0;
      y_q       <= 8'd0;
      p_q       <= 8'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        a_q <= a_d;
        x_q <= x_d;
        y_q <= y_d;
        p_q <= p_d;
      end
      if (!out_vld_q || rsp_o.ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      we_q   <= we_d;
      wd_q   <= wd_d;
      npc_q  <= npc_d;
      halt_q <= halt_d;
      bad_q  <= bad_d;
    end
  end

  // The result register holds the post-instruction state; state only moves on advance
  logic [7:0] ra_q, rx_q, ry_q, rp_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ra_q <= a_d;
      rx_q <= x_d;
      ry_q <= y_d;
      rp_q <= p_d;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.a_out        = ra_q;
  assign rsp_o.x_out        = rx_q;
  assign rsp_o.y_out        = ry_q;
  assign rsp_o.p_out        = rp_q;
  assign rsp_o.write_enable = we_q;
  assign rsp_o.write_data   = wd_q;
  assign rsp_o.next_pc      = npc_q;
  assign rsp_o.halted       = halt_q;
  assign rsp_o.illegal      = bad_q;

endmodule

>>> tb/cpu_6502_execute_unit_test.sv
// Testbench for the 6502 execute unit: directed and random instruction streams checked per result.
`timescale 1ns / 1ps

module cpu_6502_execute_unit_test;

  // Addressing form not named in the package
  localparam logic [2:0] MODE_INDY = 3'd4;

  localparam int unsigned RANDOM_PER_PHASE = 350;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES     = 8;

  // One expected result of the execute unit
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  p;
    logic        we;
    logic [7:0]  wd;
    logic [15:0] npc;
    logic        halt;
    logic        ill;
  } exec_out_t;

  logic clk_i;
  logic rst_ni;

  c6502eu_in_if  req_if ();
  c6502eu_out_if rsp_if ();

  cpu_6502_execute_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Architectural state as the testbench tracks it
  logic [7:0] sim_a;
  logic [7:0] sim_x;
  logic [7:0] sim_y;
  logic [7:0] sim_p;

  exec_out_t  pending_outputs[$];
  logic [7:0] legal_ops[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned error_count;
  int unsigned directed_sent;
  int unsigned random_sent;
  int unsigned results_checked;
  int unsigned idle_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Opcode builders
  function automatic logic [7:0] alu_code(input logic [2:0] grp, input logic [2:0] mode);
    return {grp, mode, c6502eu_pkg::COL_ALU};
  endfunction

  function automatic logic [7:0] shift_code(input logic [2:0] grp, input logic [2:0] mode);
    return {grp, mode, c6502eu_pkg::COL_SHIFT};
  endfunction

  function automatic logic [7:0] branch_code(input logic [1:0] sel, input logic on_set);
    return {sel, on_set, c6502eu_pkg::BRANCH_LOW};
  endfunction

  function automatic void set_zn(input logic [7:0] v);
    sim_p[c6502eu_pkg::FLAG_Z] = (v == 8'h00);
    sim_p[c6502eu_pkg::FLAG_N] = v[7];
  endfunction

  // Executes one instruction on the tracked state and returns the expected outputs
  function automatic exec_out_t run_instruction(input logic [7:0] op, input logic [7:0] opd,
                                                input logic [15:0] pc);
    exec_out_t  res;
    logic [2:0] grp;
    logic [2:0] mode;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] src;
    logic [7:0] r;
    logic       flag;
    grp  = op[7:5];
    mode = op[4:2];
    res  = '0;
    res.npc = pc;
    if (op[1:0] == c6502eu_pkg::COL_ALU &&
        !(grp == c6502eu_pkg::GRP_STA && mode == c6502eu_pkg::MODE_IMM) &&
        grp != c6502eu_pkg::GRP_CMP) begin
      case (grp)
        c6502eu_pkg::GRP_ORA: begin
          sim_a = sim_a | opd;
          set_zn(sim_a);
        end
        c6502eu_pkg::GRP_AND: begin
          sim_a = sim_a & opd;
          set_zn(sim_a);
        end
        c6502eu_pkg::GRP_EOR: begin
          sim_a = sim_a ^ opd;
          set_zn(sim_a);
        end
        c6502eu_pkg::GRP_STA: begin
          res.we = 1'b1;
          res.wd = sim_a;
        end
        c6502eu_pkg::GRP_LDA: begin
          sim_a = opd;
          set_zn(sim_a);
        end
        default: begin
          // ADC, and SBC as ADC of the inverted operand
          addend = (grp == c6502eu_pkg::GRP_SBC) ? ~opd : opd;
          sum = {1'b0, sim_a} + {1'b0, addend} + {8'd0, sim_p[c6502eu_pkg::FLAG_C]};
          sim_p[c6502eu_pkg::FLAG_C] = sum[8];
          sim_p[c6502eu_pkg::FLAG_V] = ~(sim_a[7] ^ addend[7]) & (sim_a[7] ^ sum[7]);
          sim_a = sum[7:0];
          set_zn(sim_a);
        end
      endcase
    end else if (op[1:0] == c6502eu_pkg::COL_SHIFT &&
                 (grp == c6502eu_pkg::GRP_ASL || grp == c6502eu_pkg::GRP_LSR) &&
                 (mode == c6502eu_pkg::MODE_ZP || mode == c6502eu_pkg::MODE_IMM ||
                  mode == c6502eu_pkg::MODE_ABS || mode == c6502eu_pkg::MODE_ZPX ||
                  mode == c6502eu_pkg::MODE_ABSX)) begin
      // accumulator form sits in the immediate slot
      src = (mode == c6502eu_pkg::MODE_IMM) ? sim_a : opd;
      if (grp == c6502eu_pkg::GRP_ASL) begin
        sim_p[c6502eu_pkg::FLAG_C] = src[7];
        r = {src[6:0], 1'b0};
      end else begin
        sim_p[c6502eu_pkg::FLAG_C] = src[0];
        r = {1'b0, src[7:1]};
      end
      set_zn(r);
      if (mode == c6502eu_pkg::MODE_IMM) begin
        sim_a = r;
      end else begin
        res.we = 1'b1;
        res.wd = r;
      end
    end else if (op[4:0] == c6502eu_pkg::BRANCH_LOW) begin
      case (op[7:6])
        c6502eu_pkg::BSEL_N: flag = sim_p[c6502eu_pkg::FLAG_N];
        c6502eu_pkg::BSEL_V: flag = sim_p[c6502eu_pkg::FLAG_V];
        c6502eu_pkg::BSEL_C: flag = sim_p[c6502eu_pkg::FLAG_C];
        default:             flag = sim_p[c6502eu_pkg::FLAG_Z];
      endcase
      // bit 5 selects branch on set or on clear
      if (op[5] == flag) res.npc = pc + {{8{opd[7]}}, opd};
    end else if (op == c6502eu_pkg::OP_BIT_ZP || op == c6502eu_pkg::OP_BIT_ABS) begin
      sim_p[c6502eu_pkg::FLAG_Z] = ((sim_a & opd) == 8'h00);
      sim_p[c6502eu_pkg::FLAG_N] = opd[7];
      sim_p[c6502eu_pkg::FLAG_V] = opd[6];
    end else if (op == c6502eu_pkg::OP_TAX) begin
      sim_x = sim_a;
      set_zn(sim_x);
    end else if (op == c6502eu_pkg::OP_INX) begin
      sim_x = sim_x + 8'd1;
      set_zn(sim_x);
    end else if (op == c6502eu_pkg::OP_INY) begin
      sim_y = sim_y + 8'd1;
      set_zn(sim_y);
    end else if (op == c6502eu_pkg::OP_NOP) begin
      // nothing changes
    end else if (op == c6502eu_pkg::OP_BRK) begin
      res.halt = 1'b1;
    end else begin
      res.ill = 1'b1;
    end
    res.a = sim_a;
    res.x = sim_x;
    res.y = sim_y;
    res.p = sim_p;
    return res;
  endfunction

  // Sends one request, with a random gap first; valid stays high after acceptance
  task automatic send_instr(input logic [7:0] op, input logic [7:0] opd, input logic [15:0] pc);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.operand  <= opd;
    req_if.pc_after <= pc;
    do @(posedge clk_i); while (!req_if.ready);
    pending_outputs.push_back(run_instruction(op, opd, pc));
  endtask

  // Implemented opcode table for the random stream
  task automatic build_legal_ops();
    logic [2:0] g;
    logic [2:0] m;
    for (int gi = 0; gi < 8; gi++) begin
      g = gi[2:0];
      for (int mi = 0; mi < 8; mi++) begin
        m = mi[2:0];
        if (g != c6502eu_pkg::GRP_CMP &&
            !(g == c6502eu_pkg::GRP_STA && m == c6502eu_pkg::MODE_IMM))
          legal_ops.push_back(alu_code(g, m));
        if ((g == c6502eu_pkg::GRP_ASL || g == c6502eu_pkg::GRP_LSR) &&
            (m == c6502eu_pkg::MODE_ZP || m == c6502eu_pkg::MODE_IMM ||
             m == c6502eu_pkg::MODE_ABS || m == c6502eu_pkg::MODE_ZPX ||
             m == c6502eu_pkg::MODE_ABSX))
          legal_ops.push_back(shift_code(g, m));
      end
    end
    for (int bi = 0; bi < 4; bi++) begin
      legal_ops.push_back(branch_code(bi[1:0], 1'b0));
      legal_ops.push_back(branch_code(bi[1:0], 1'b1));
    end
    legal_ops.push_back(c6502eu_pkg::OP_BIT_ZP);
    legal_ops.push_back(c6502eu_pkg::OP_BIT_ABS);
    legal_ops.push_back(c6502eu_pkg::OP_TAX);
    legal_ops.push_back(c6502eu_pkg::OP_INX);
    legal_ops.push_back(c6502eu_pkg::OP_INY);
    legal_ops.push_back(c6502eu_pkg::OP_NOP);
    legal_ops.push_back(c6502eu_pkg::OP_BRK);
  endtask

  // Random instructions: mostly implemented opcodes, the rest any byte
  task automatic run_random(input int unsigned count);
    logic [7:0]  op;
    logic [7:0]  opd;
    logic [15:0] pc;
    repeat (count) begin
      if ($urandom_range(0, 99) < 80) op = legal_ops[$urandom_range(0, legal_ops.size() - 1)];
      else op = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0:       opd = 8'h00;
        1:       opd = 8'hFF;
        2:       opd = 8'h80;
        3:       opd = 8'h7F;
        default: opd = 8'($urandom_range(0, 255));
      endcase
      // addresses near both ends make branch targets wrap
      case ($urandom_range(0, 3))
        0:       pc = 16'($urandom_range(0, 127));
        1:       pc = 16'($urandom_range(16'hFF80, 16'hFFFF));
        default: pc = 16'($urandom_range(0, 65535));
      endcase
      send_instr(op, opd, pc);
      random_sent++;
    end
  endtask

  // Directed: every operation, flag extremes, taken and wrapping branches, BRK, unknown opcode
  task automatic test_directed_ops();
    send_instr(alu_code(c6502eu_pkg::GRP_LDA, c6502eu_pkg::MODE_IMM), 8'h00, 16'h0002);
    send_instr(alu_code(c6502eu_pkg::GRP_LDA, c6502eu_pkg::MODE_IMM), 8'hFF, 16'h0004);
    send_instr(c6502eu_pkg::OP_TAX, 8'h00, 16'h0005);
    send_instr(c6502eu_pkg::OP_INX, 8'h00, 16'h0006);
    send_instr(c6502eu_pkg::OP_INY, 8'h00, 16'h0007);
    send_instr(alu_code(c6502eu_pkg::GRP_ADC, c6502eu_pkg::MODE_IMM), 8'h01, 16'h0009);
    send_instr(alu_code(c6502eu_pkg::GRP_ADC, c6502eu_pkg::MODE_IMM), 8'h7F, 16'h000B);
    // overflow and negative set: taken branches wrap both ways
    send_instr(branch_code(c6502eu_pkg::BSEL_V, 1'b1), 8'h80, 16'h0005);
    send_instr(branch_code(c6502eu_pkg::BSEL_N, 1'b1), 8'h7F, 16'hFFF0);
    send_instr(branch_code(c6502eu_pkg::BSEL_V, 1'b0), 8'h10, 16'h1234);
    send_instr(branch_code(c6502eu_pkg::BSEL_N, 1'b0), 8'hF0, 16'h1234);
    send_instr(alu_code(c6502eu_pkg::GRP_SBC, c6502eu_pkg::MODE_IMM), 8'hFF, 16'h0100);
    send_instr(alu_code(c6502eu_pkg::GRP_AND, c6502eu_pkg::MODE_ZP), 8'h0F, 16'h0102);
    send_instr(alu_code(c6502eu_pkg::GRP_ORA, c6502eu_pkg::MODE_ABS), 8'hF0, 16'h0105);
    send_instr(alu_code(c6502eu_pkg::GRP_EOR, MODE_INDY), 8'hFF, 16'h0107);
    send_instr(alu_code(c6502eu_pkg::GRP_STA, c6502eu_pkg::MODE_ZP), 8'h55, 16'h0109);
    send_instr(shift_code(c6502eu_pkg::GRP_ASL, c6502eu_pkg::MODE_IMM), 8'h00, 16'h010A);
    send_instr(shift_code(c6502eu_pkg::GRP_ASL, c6502eu_pkg::MODE_ZP), 8'h80, 16'h010C);
    send_instr(branch_code(c6502eu_pkg::BSEL_C, 1'b1), 8'h02, 16'h0200);
    send_instr(branch_code(c6502eu_pkg::BSEL_Z, 1'b1), 8'hFE, 16'h0300);
    send_instr(shift_code(c6502eu_pkg::GRP_LSR, c6502eu_pkg::MODE_IMM), 8'h00, 16'h0301);
    send_instr(shift_code(c6502eu_pkg::GRP_LSR, c6502eu_pkg::MODE_ABSX), 8'h01, 16'h0304);
    send_instr(branch_code(c6502eu_pkg::BSEL_C, 1'b0), 8'h40, 16'h0400);
    send_instr(branch_code(c6502eu_pkg::BSEL_Z, 1'b0), 8'hC0, 16'h0400);
    send_instr(c6502eu_pkg::OP_BIT_ZP, 8'hC0, 16'h0402);
    send_instr(c6502eu_pkg::OP_BIT_ABS, 8'h00, 16'h0405);
    send_instr(c6502eu_pkg::OP_NOP, 8'hAA, 16'h0406);
    send_instr(c6502eu_pkg::OP_BRK, 8'h00, 16'hFFFF);
    send_instr(alu_code(c6502eu_pkg::GRP_STA, c6502eu_pkg::MODE_IMM), 8'h12, 16'h0408);
    directed_sent = 29;
  endtask

  task automatic test_stalled_receiver();
    src_idle_pct  = 10;
    sink_idle_pct = 62;
    run_random(RANDOM_PER_PHASE);
  endtask

  task automatic test_stalled_sender();
    src_idle_pct  = 62;
    sink_idle_pct = 10;
    run_random(RANDOM_PER_PHASE);
  endtask

  task automatic test_full_rate();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      error_count++;
    end
  endfunction

  // Receiver back-pressure
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    exec_out_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result with no instruction outstanding");
        error_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("a_out", 16'(want.a), 16'(rsp_if.a_out));
        check_field("x_out", 16'(want.x), 16'(rsp_if.x_out));
        check_field("y_out", 16'(want.y), 16'(rsp_if.y_out));
        check_field("p_out", 16'(want.p), 16'(rsp_if.p_out));
        check_field("write_enable", 16'(want.we), 16'(rsp_if.write_enable));
        check_field("write_data", 16'(want.wd), 16'(rsp_if.write_data));
        check_field("next_pc", want.npc, rsp_if.next_pc);
        check_field("halted", 16'(want.halt), 16'(rsp_if.halted));
        check_field("illegal", 16'(want.ill), 16'(rsp_if.illegal));
        results_checked++;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.opcode   <= c6502eu_pkg::OP_NOP;
    req_if.operand  <= 8'h00;
    req_if.pc_after <= 16'h0000;
    sim_a           = 8'h00;
    sim_x           = 8'h00;
    sim_y           = 8'h00;
    sim_p           = 8'h00;
    error_count     = 0;
    directed_sent   = 0;
    random_sent     = 0;
    results_checked = 0;
    src_idle_pct    = 10;
    sink_idle_pct   = 62;
    build_legal_ops();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_stalled_receiver();
    test_stalled_sender();
    test_full_rate();

    req_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d directed and %0d random instructions, %0d results checked,",
             directed_sent, random_sent, results_checked);
    $display("under slow-receiver, slow-sender and full-rate handshake pacing.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/c6502eu_pkg.sv
src/c6502eu_if.sv
src/cpu_6502_execute_unit.sv
tb/cpu_6502_execute_unit_test.sv
